>>> rtl/rict_pkg.sv
// Shared types and codes for the remote ID channel table.
// No dependencies; used by remote_id_channel_table.
`default_nettype none

package rict_pkg;

   localparam int ID_W    = 32;
   localparam int CHAN_W  = 16;
   localparam int SLOT_W  = 4;
   localparam int ENTRY_W = ID_W + CHAN_W;

   // entry layout: channel mask above the ID
   localparam logic [ENTRY_W-1:0] ERASED_ENTRY = {ENTRY_W{1'b1}};

   localparam logic [1:0] FUNC_COMPARE = 2'd0;
   localparam logic [1:0] FUNC_SAVE    = 2'd1;
   localparam logic [1:0] FUNC_ADD     = 2'd2;
   localparam logic [1:0] FUNC_REMOVE  = 2'd3;

   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_REJECTED  = 2'd1;
   localparam logic [1:0] STATUS_OVERWROTE = 2'd2;

   typedef struct packed {
      logic [1:0]        func;
      logic [ID_W-1:0]   id_value;
      logic [CHAN_W-1:0] chan_mask;
      logic [SLOT_W-1:0] slot;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] found_slot;
      logic              channel_overlap;
      logic [1:0]        status;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/rict_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module rict_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 10
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/remote_id_channel_table.sv
// Remote ID channel table: top level, scan and read-modify-write control.
// Depends on rict_pkg and rict_ram.
`default_nettype none
//
//  channel   direction   handshake            payload
//  req_      in          req_valid/req_stall  rict_pkg::req_type
//  rsp_      out         rsp_valid/rsp_stall  rict_pkg::rsp_type
//  csr_      in          csr_valid/csr_ready  head_marker, 8 bits
//
//  Compare and save walk the entry RAM one entry per cycle, reading ahead
//  while the current entry is checked. The result is loaded once the result
//  register is free; the next request is taken after that. Add and remove
//  take one read and one write-back; a remove that clears the last channel
//  only marks the entry erased. A rejected slot does not touch the RAM.
//  Synchronous reset marks every entry erased through the valid bits; no
//  clearing pass is needed. A result waiting under rsp_stall does not block
//  acceptance of the next request, only the loading of its result.

module remote_id_channel_table #(
   parameter int ENTRIES = 10
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire rict_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rict_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [7:0]        csr_data
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MOD,
      ST_OUT
   } state_type;

   state_type                      state_ff, state_in;
   rict_pkg::req_type              req_ff;
   rict_pkg::rsp_type              res_ff, res_in;
   rict_pkg::rsp_type              rsp_ff;
   logic                           rsp_valid_ff;
   logic [IDX_W-1:0]               idx_ff, idx_in;
   logic [ENTRIES-1:0]             vld_ff;
   logic [7:0]                     marker_ff;

   // RAM port signals
   logic                           wr_en, rd_en;
   logic [IDX_W-1:0]               wr_addr, rd_addr;
   logic [rict_pkg::ENTRY_W-1:0]   wr_data, rd_data;

   // valid-bit updates
   logic                           vld_set, vld_clr;

   // current entry as stored, erased where its valid bit is clear
   logic [rict_pkg::ENTRY_W-1:0]   entry;
   logic [rict_pkg::ID_W-1:0]      e_id;
   logic [rict_pkg::CHAN_W-1:0]    e_chan, new_chan;
   logic                           accept, slot_bad, rsp_free;
   logic [rict_pkg::SLOT_W-1:0]    idx_slot;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign slot_bad = (req_data.slot == '0) ||
                     (req_data.slot > rict_pkg::SLOT_W'(ENTRIES));

   assign entry    = vld_ff[idx_ff] ? rd_data : rict_pkg::ERASED_ENTRY;
   assign e_id     = entry[rict_pkg::ID_W-1:0];
   assign e_chan   = entry[rict_pkg::ENTRY_W-1:rict_pkg::ID_W];
   assign idx_slot = rict_pkg::SLOT_W'(idx_ff) + rict_pkg::SLOT_W'(1);

   always_comb begin
      state_in = state_ff;
      res_in   = res_ff;
      idx_in   = idx_ff;
      rd_en    = 1'b0;
      rd_addr  = '0;
      wr_en    = 1'b0;
      wr_addr  = idx_ff;
      wr_data  = {req_ff.chan_mask, req_ff.id_value};
      vld_set  = 1'b0;
      vld_clr  = 1'b0;
      new_chan = e_chan;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_in = '{found_slot: '0, channel_overlap: 1'b0,
                          status: rict_pkg::STATUS_DONE};
               if (req_data.func == rict_pkg::FUNC_COMPARE ||
                   req_data.func == rict_pkg::FUNC_SAVE) begin
                  // start the scan at entry 0
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  idx_in   = '0;
                  state_in = ST_SCAN;
               end else if (slot_bad) begin
                  res_in.status = rict_pkg::STATUS_REJECTED;
                  state_in      = ST_OUT;
               end else begin
                  // fetch the addressed entry for read-modify-write
                  rd_en    = 1'b1;
                  rd_addr  = IDX_W'(req_data.slot - rict_pkg::SLOT_W'(1));
                  idx_in   = rd_addr;
                  state_in = ST_MOD;
               end
            end
         end

         ST_SCAN: begin
            // read ahead one entry while the current one is checked
            rd_en   = (idx_ff != LAST_IDX);
            rd_addr = idx_ff + IDX_W'(1);
            idx_in  = rd_addr;
            if (req_ff.func == rict_pkg::FUNC_COMPARE) begin
               if (e_id == req_ff.id_value) begin
                  res_in.found_slot = idx_slot;
                  if ((e_chan & req_ff.chan_mask) != '0) begin
                     res_in.channel_overlap = 1'b1;
                     state_in               = ST_OUT;
                  end
               end
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_OUT;
               end
            end else begin
               // save: first entry without the marker, else the last entry
               if (entry[7:0] != marker_ff || idx_ff == LAST_IDX) begin
                  wr_en             = 1'b1;
                  wr_addr           = idx_ff;
                  vld_set           = 1'b1;
                  res_in.found_slot = idx_slot;
                  if (entry[7:0] == marker_ff) begin
                     res_in.status = rict_pkg::STATUS_OVERWROTE;
                  end
                  state_in = ST_OUT;
               end
            end
         end

         ST_MOD: begin
            if (req_ff.func == rict_pkg::FUNC_ADD) begin
               new_chan = e_chan | req_ff.chan_mask;
            end else begin
               new_chan = e_chan & ~req_ff.chan_mask;
            end
            wr_data = {new_chan, e_id};
            if (req_ff.func == rict_pkg::FUNC_REMOVE && new_chan == '0) begin
               // last channel gone: drop the entry back to erased
               vld_clr = 1'b1;
            end else begin
               wr_en   = 1'b1;
               vld_set = 1'b1;
            end
            state_in = ST_OUT;
         end

         ST_OUT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= '0;
         marker_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            marker_ff <= csr_data;
         end
         if (vld_set) begin
            vld_ff[idx_ff] <= 1'b1;
         end else if (vld_clr) begin
            vld_ff[idx_ff] <= 1'b0;
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_OUT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end
      end
      // payload holds
      res_ff <= res_in;
      idx_ff <= idx_in;
      if (accept) begin
         req_ff <= req_data;
      end
      if (state_ff == ST_OUT && rsp_free) begin
         rsp_ff <= res_ff;
      end
   end

   rict_ram #(
      .WIDTH (rict_pkg::ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   a_write_in_work: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_SCAN || state_ff == ST_MOD))
      else $error("entry write outside scan or modify");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("result appeared without finishing a request");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("accepted request did not start");

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == rict_pkg::STATUS_REJECTED) |->
      (rsp_ff.found_slot == '0 && !rsp_ff.channel_overlap))
      else $error("rejected request carries a slot or overlap");

endmodule

`default_nettype wire
